// ===== rtl/assert_macros.svh =====
// assertion macros shared by the union-find maze unit
// each use expands to one labeled concurrent assertion on clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define GSTUF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define GSTUF_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/gstuf_pkg.sv =====
// types, constants and state codes of the union-find maze unit
// used by every module in rtl but gstuf_ram, no dependencies
package gstuf_pkg;

  localparam int MAX_COLS  = 32;
  localparam int MAX_ROWS  = 128;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CELLS     = MAX_COLS * MAX_ROWS;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int COLS_CFG_W = 6;
  localparam int ROWS_CFG_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int QDEPTH    = 2;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = CFG_IDX_W'(1);

  localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(30);
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(80);

  localparam logic [3:0] W_UP    = 4'b0001;
  localparam logic [3:0] W_DOWN  = 4'b0010;
  localparam logic [3:0] W_LEFT  = 4'b0100;
  localparam logic [3:0] W_RIGHT = 4'b1000;
  localparam logic [3:0] W_ALL   = 4'b1111;

  localparam logic KIND_CLEAR = 1'b0;
  localparam logic TOWARD_RIGHT = 1'b0;

  typedef struct packed {
    logic             kind;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic             toward;
  } in_item_t;

  typedef struct packed {
    logic       edge_inside;
    logic       joined;
    logic [3:0] first_walls;
    logic [3:0] second_walls;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_EDGE,
    OP_OUT_FIRST,
    OP_OUT_SECOND
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] addr_a;
    logic [CELL_W-1:0] addr_b;
    logic              toward;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CLR,
    B_RDW_A,
    B_RDW_B,
    B_FSTART,
    B_FIND_P,
    B_FIND_G,
    B_UNION,
    B_UNION2,
    B_OUT
  } bstate_t;

endpackage

// ===== rtl/gstuf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module gstuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gstuf_front.sv =====
// front end: grid size registers, input accept and edge classification
// depends on gstuf_pkg
module gstuf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gstuf_pkg::in_item_t                 in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gstuf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gstuf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                q_ready,
  output logic                                push,
  output gstuf_pkg::cmd_t                     cmd
);

  logic [gstuf_pkg::COLS_CFG_W-1:0] cols_r, cols_nxt;
  logic [gstuf_pkg::ROWS_CFG_W-1:0] rows_r, rows_nxt;
  logic [gstuf_pkg::COLS_CFG_W-1:0] eff_cols;
  logic [gstuf_pkg::ROWS_CFG_W-1:0] eff_rows;
  logic [gstuf_pkg::COLS_CFG_W-1:0] col_x, nc;
  logic [gstuf_pkg::ROWS_CFG_W-1:0] row_x, nr;
  logic first_in, second_in;

  assign cfg_ready = 1'b1;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gstuf_pkg::CFG_GRID_COLS: cols_nxt = cfg_data[gstuf_pkg::COLS_CFG_W-1:0];
        gstuf_pkg::CFG_GRID_ROWS: rows_nxt = cfg_data[gstuf_pkg::ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= gstuf_pkg::COLS_RESET;
      rows_r <= gstuf_pkg::ROWS_RESET;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  // zero acts as one, anything above the store size acts as the store size
  always_comb begin
    priority if (cols_r == '0) begin
      eff_cols = gstuf_pkg::COLS_CFG_W'(1);
    end else if (cols_r > gstuf_pkg::COLS_CFG_W'(gstuf_pkg::MAX_COLS)) begin
      eff_cols = gstuf_pkg::COLS_CFG_W'(gstuf_pkg::MAX_COLS);
    end else begin
      eff_cols = cols_r;
    end
    priority if (rows_r == '0) begin
      eff_rows = gstuf_pkg::ROWS_CFG_W'(1);
    end else if (rows_r > gstuf_pkg::ROWS_CFG_W'(gstuf_pkg::MAX_ROWS)) begin
      eff_rows = gstuf_pkg::ROWS_CFG_W'(gstuf_pkg::MAX_ROWS);
    end else begin
      eff_rows = rows_r;
    end
  end

  always_comb begin
    col_x = gstuf_pkg::COLS_CFG_W'(in_data.cell_col);
    row_x = gstuf_pkg::ROWS_CFG_W'(in_data.cell_row);
    nc = col_x + gstuf_pkg::COLS_CFG_W'(in_data.toward == gstuf_pkg::TOWARD_RIGHT);
    nr = row_x + gstuf_pkg::ROWS_CFG_W'(in_data.toward != gstuf_pkg::TOWARD_RIGHT);
    first_in  = (col_x < eff_cols) && (row_x < eff_rows);
    second_in = (nc < eff_cols) && (nr < eff_rows);

    priority if (in_data.kind == gstuf_pkg::KIND_CLEAR) begin
      cmd.op = gstuf_pkg::OP_CLEAR;
    end else if (!first_in) begin
      cmd.op = gstuf_pkg::OP_OUT_FIRST;
    end else if (!second_in) begin
      cmd.op = gstuf_pkg::OP_OUT_SECOND;
    end else begin
      cmd.op = gstuf_pkg::OP_EDGE;
    end
    // cell (c, r) sits at r * MAX_COLS + c
    cmd.addr_a = {in_data.cell_row, in_data.cell_col};
    cmd.addr_b = {nr[gstuf_pkg::ROW_W-1:0], nc[gstuf_pkg::COL_W-1:0]};
    cmd.toward = in_data.toward;
  end

  assign in_stall = !q_ready;
  assign push     = in_valid && q_ready;

endmodule

// ===== rtl/gstuf_queue.sv =====
// short command queue between front and back end
// depends on gstuf_pkg and assert_macros.svh
`include "assert_macros.svh"

module gstuf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  gstuf_pkg::cmd_t cmd_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gstuf_pkg::cmd_t cmd_o
);

  gstuf_pkg::cmd_t mem_r [gstuf_pkg::QDEPTH];
  logic [gstuf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gstuf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gstuf_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign ready_o = count_r != gstuf_pkg::QCNT_W'(gstuf_pkg::QDEPTH);
  assign valid_o = count_r != '0;
  assign cmd_o   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == gstuf_pkg::QPTR_W'(gstuf_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == gstuf_pkg::QPTR_W'(gstuf_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= cmd_i;
    end
  end

  `GSTUF_NEVER(a_q_overflow, push_i && !ready_o, "queue push while full")
  `GSTUF_NEVER(a_q_underflow, pop_i && !valid_o, "queue pop while empty")

endmodule

// ===== rtl/gstuf_back.sv =====
// back end: clear sweep, two find walks with path halving, union and result register
// depends on gstuf_pkg, gstuf_ram and assert_macros.svh
`include "assert_macros.svh"

module gstuf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  gstuf_pkg::cmd_t      q_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gstuf_pkg::out_item_t out_data
);

  localparam int CW = gstuf_pkg::CELL_W;

  gstuf_pkg::bstate_t   state_r, state_nxt;
  gstuf_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [CW-1:0]        x_r, x_nxt;
  logic [CW-1:0]        ra_r, ra_nxt;
  logic                 which_r, which_nxt;
  logic [CW-1:0]        step_r, step_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [3:0]           fw_r, fw_nxt;
  logic [3:0]           sw_r, sw_nxt;
  logic                 joined_r, joined_nxt;
  logic                 out_valid_r, out_valid_nxt;
  gstuf_pkg::out_item_t out_data_r, out_data_nxt;
  logic                 out_ld;

  logic          link_we;
  logic [CW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
  logic          wall_we;
  logic [CW-1:0] wall_waddr, wall_raddr;
  logic [3:0]    wall_wdata, wall_rdata;

  gstuf_ram #(.WIDTH(CW), .DEPTH(gstuf_pkg::CELLS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  gstuf_ram #(.WIDTH(4), .DEPTH(gstuf_pkg::CELLS)) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (wall_waddr),
    .wdata (wall_wdata),
    .raddr (wall_raddr),
    .rdata (wall_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gstuf_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    x_r        <= x_nxt;
    ra_r       <= ra_nxt;
    which_r    <= which_nxt;
    step_r     <= step_nxt;
    cnt_r      <= cnt_nxt;
    fw_r       <= fw_nxt;
    sw_r       <= sw_nxt;
    joined_r   <= joined_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    x_nxt      = x_r;
    ra_nxt     = ra_r;
    which_nxt  = which_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    fw_nxt     = fw_r;
    sw_nxt     = sw_r;
    joined_nxt = joined_r;
    pop        = 1'b0;
    out_ld     = 1'b0;
    link_we    = 1'b0;
    link_waddr = x_r;
    link_wdata = link_rdata;
    link_raddr = x_r;
    wall_we    = 1'b0;
    wall_waddr = cmd_r.addr_a;
    wall_wdata = fw_r;
    wall_raddr = cmd_r.addr_a;

    unique case (state_r)
      gstuf_pkg::B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          cmd_nxt    = q_cmd;
          fw_nxt     = '0;
          sw_nxt     = '0;
          joined_nxt = 1'b0;
          cnt_nxt    = '0;
          unique case (q_cmd.op)
            gstuf_pkg::OP_CLEAR:     state_nxt = gstuf_pkg::B_CLR;
            gstuf_pkg::OP_OUT_FIRST: state_nxt = gstuf_pkg::B_OUT;
            gstuf_pkg::OP_OUT_SECOND,
            gstuf_pkg::OP_EDGE:      state_nxt = gstuf_pkg::B_RDW_A;
            default:                 state_nxt = gstuf_pkg::B_IDLE;
          endcase
        end
      end
      gstuf_pkg::B_CLR: begin
        link_we    = 1'b1;
        link_waddr = cnt_r;
        link_wdata = cnt_r;
        wall_we    = 1'b1;
        wall_waddr = cnt_r;
        wall_wdata = gstuf_pkg::W_ALL;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = gstuf_pkg::B_OUT;
        end
      end
      gstuf_pkg::B_RDW_A: begin
        wall_raddr = cmd_r.addr_a;
        state_nxt  = gstuf_pkg::B_RDW_B;
      end
      gstuf_pkg::B_RDW_B: begin
        fw_nxt     = wall_rdata;
        wall_raddr = cmd_r.addr_b;
        state_nxt  = (cmd_r.op == gstuf_pkg::OP_EDGE) ? gstuf_pkg::B_FSTART
                   : gstuf_pkg::B_OUT;
      end
      gstuf_pkg::B_FSTART: begin
        sw_nxt     = wall_rdata;
        link_raddr = cmd_r.addr_a;
        x_nxt      = cmd_r.addr_a;
        which_nxt  = 1'b0;
        step_nxt   = '0;
        state_nxt  = gstuf_pkg::B_FIND_P;
      end
      gstuf_pkg::B_FIND_P: begin
        // link_rdata holds the parent of x_r; a root links to itself
        if (link_rdata == x_r || step_r == '1) begin
          if (!which_r) begin
            ra_nxt     = x_r;
            x_nxt      = cmd_r.addr_b;
            link_raddr = cmd_r.addr_b;
            which_nxt  = 1'b1;
            step_nxt   = '0;
          end else begin
            state_nxt = gstuf_pkg::B_UNION;
          end
        end else begin
          link_raddr = link_rdata;
          step_nxt   = step_r + 1'b1;
          state_nxt  = gstuf_pkg::B_FIND_G;
        end
      end
      gstuf_pkg::B_FIND_G: begin
        // path halving: point x at its grandparent and continue from there
        link_we    = 1'b1;
        link_waddr = x_r;
        link_wdata = link_rdata;
        x_nxt      = link_rdata;
        link_raddr = link_rdata;
        state_nxt  = gstuf_pkg::B_FIND_P;
      end
      gstuf_pkg::B_UNION: begin
        // x_r is the second root here
        if (ra_r != x_r) begin
          link_we    = 1'b1;
          link_waddr = ra_r;
          link_wdata = x_r;
          joined_nxt = 1'b1;
          if (cmd_r.toward == gstuf_pkg::TOWARD_RIGHT) begin
            fw_nxt = fw_r & ~gstuf_pkg::W_RIGHT;
            sw_nxt = sw_r & ~gstuf_pkg::W_LEFT;
          end else begin
            fw_nxt = fw_r & ~gstuf_pkg::W_DOWN;
            sw_nxt = sw_r & ~gstuf_pkg::W_UP;
          end
          wall_we    = 1'b1;
          wall_waddr = cmd_r.addr_a;
          wall_wdata = fw_nxt;
          state_nxt  = gstuf_pkg::B_UNION2;
        end else begin
          state_nxt = gstuf_pkg::B_OUT;
        end
      end
      gstuf_pkg::B_UNION2: begin
        wall_we    = 1'b1;
        wall_waddr = cmd_r.addr_b;
        wall_wdata = sw_r;
        state_nxt  = gstuf_pkg::B_OUT;
      end
      gstuf_pkg::B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_ld    = 1'b1;
          state_nxt = gstuf_pkg::B_IDLE;
        end
      end
      default: state_nxt = gstuf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (out_ld) begin
      out_data_nxt.edge_inside  = cmd_r.op == gstuf_pkg::OP_EDGE;
      out_data_nxt.joined       = joined_r;
      out_data_nxt.first_walls  = fw_r;
      out_data_nxt.second_walls = sw_r;
    end
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GSTUF_ASSERT(a_clr_ident, (state_r == gstuf_pkg::B_CLR) |-> (link_wdata == link_waddr), "clear sweep writes a non-root link")
  `GSTUF_ASSERT(a_out_free, out_ld |-> (!out_valid_r || !out_stall), "result loaded over a held word")
  `GSTUF_ASSERT(a_join_roots, ((state_r == gstuf_pkg::B_OUT) && joined_r) |-> (ra_r != x_r), "joined with equal roots")

endmodule

// ===== rtl/grid_spanning_tree_union_find_unit.sv =====
// Maze carving unit over a grid with a disjoint-set store (spanning tree carving).
// Input channel in_valid/in_stall/in_data: a clear word resets every cell to a
// set of its own with all four walls up; an edge word offers the first cell and
// its right or lower neighbour, and joins the two sets if they differ.
// Output channel out_valid/out_stall/out_data: exactly one result word per input
// word, in order (edge_inside, joined, first_walls, second_walls).
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 grid_cols,
// index 1 grid_rows; cfg_ready is always high; write only while idle.
// An edge walks both finds in turn and writes the walls back only when the sets
// are joined; a clear sweeps all 4096 store entries, one entry a cycle. One word
// is carried out at a time, set by the single read port of the link ram that
// both find walks share.
// A two-word queue sits between accept and execution, so in_stall rises only
// when it is full; a stalled result is held in the output register while the
// next word is already being worked on.
// Reset clears the control state and restores 30 columns and 80 rows; the store
// contents are undefined until the first clear word.
// Depends on gstuf_pkg, gstuf_front, gstuf_queue, gstuf_back and gstuf_ram.
module grid_spanning_tree_union_find_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gstuf_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gstuf_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gstuf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gstuf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic            push, q_ready, q_valid, pop;
  gstuf_pkg::cmd_t push_cmd, q_cmd;

  gstuf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ready   (q_ready),
    .push      (push),
    .cmd       (push_cmd)
  );

  gstuf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  gstuf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
